### design/pifc_pkg.sv
// ----------------------------------------------------------------------------
// pifc_pkg
// Shared register indexes and types of the point-in-finite-cylinder
// classifier.
// ----------------------------------------------------------------------------
package pifc_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_X         = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_Y         = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_Z         = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_AXIS_X         = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_AXIS_Y         = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_AXIS_Z         = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS         = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BAND_HALFWIDTH = 3'd7;

    // status of the precomputed cylinder geometry
    typedef struct packed {
        logic axis_zero;
        logic lo_neg;
    } t_geom_flags;

endpackage

### design/pifc_geom.sv
// ----------------------------------------------------------------------------
// pifc_geom
// Free-running precompute of the cylinder terms that depend on the
// configuration only: axis length squared and the three squared radius
// limits scaled by it.
// ----------------------------------------------------------------------------
module pifc_geom #(
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic signed [COORD_BITS-1:0]     i_axis_x,
    input  logic signed [COORD_BITS-1:0]     i_axis_y,
    input  logic signed [COORD_BITS-1:0]     i_axis_z,
    input  logic        [COORD_BITS-2:0]     i_radius,
    input  logic        [COORD_BITS-2:0]     i_band_halfwidth,
    output logic        [2*COORD_BITS-1:0]   o_len2,
    output logic        [4*COORD_BITS-1:0]   o_lim_in,
    output logic        [4*COORD_BITS-1:0]   o_lim_hi,
    output logic        [4*COORD_BITS-1:0]   o_lim_lo,
    output pifc_pkg::t_geom_flags            o_flags
);
    import pifc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int L_W = 2 * COORD_BITS;
    localparam int S_W = 4 * COORD_BITS;

    logic signed [C-1:0]   w_a [3];

    logic signed [C-1:0]   r_g1_a [3];
    logic        [C-2:0]   r_g1_rad;
    logic        [C-1:0]   r_g1_hi;
    logic signed [C-1:0]   r_g1_lo;

    logic signed [L_W-1:0] n_aa [3];
    logic        [L_W-1:0] n_rr;
    logic        [L_W-1:0] n_hh;
    logic        [L_W-1:0] n_ll;
    logic        [L_W-1:0] r_g2_aa [3];
    logic        [L_W-1:0] r_g2_rr;
    logic        [L_W-1:0] r_g2_hh;
    logic        [L_W-1:0] r_g2_ll;
    logic                  r_g2_lo_neg;

    logic        [L_W-1:0] n_len2;
    logic        [L_W-1:0] r_g3_len2;
    logic        [L_W-1:0] r_g3_x [3];
    t_geom_flags           r_g3_flags;

    logic        [L_W-1:0] n_pp [3][4];
    logic        [L_W-1:0] r_g4_pp [3][4];
    t_geom_flags           r_g4_flags;

    logic        [S_W-1:0] n_lim [3];
    logic        [S_W-1:0] r_g5_lim [3];
    t_geom_flags           r_g5_flags;

    assign w_a[0] = i_axis_x;
    assign w_a[1] = i_axis_y;
    assign w_a[2] = i_axis_z;

    // stage 1: register the axis, form radius plus and minus band
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_g1_a[i] <= w_a[i];
        end
        r_g1_rad <= i_radius;
        r_g1_hi  <= {1'b0, i_radius} + {1'b0, i_band_halfwidth};
        r_g1_lo  <= $signed({1'b0, i_radius}) - $signed({1'b0, i_band_halfwidth});
    end

    // stage 2: squares
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_aa[i] = r_g1_a[i] * r_g1_a[i];
        end
        n_rr = r_g1_rad * r_g1_rad;
        n_hh = r_g1_hi * r_g1_hi;
        n_ll = r_g1_lo[C-2:0] * r_g1_lo[C-2:0];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_g2_aa[i] <= n_aa[i];
        end
        r_g2_rr     <= n_rr;
        r_g2_hh     <= n_hh;
        r_g2_ll     <= n_ll;
        r_g2_lo_neg <= r_g1_lo[C-1];
    end

    // stage 3: axis length squared
    assign n_len2 = r_g2_aa[0] + r_g2_aa[1] + r_g2_aa[2];

    always_ff @(posedge i_clk) begin
        r_g3_len2            <= n_len2;
        r_g3_x[0]            <= r_g2_rr;
        r_g3_x[1]            <= r_g2_hh;
        r_g3_x[2]            <= r_g2_ll;
        r_g3_flags.lo_neg    <= r_g2_lo_neg;
        r_g3_flags.axis_zero <= (n_len2 == '0);
    end

    // stage 4: half by half partial products of limit times length squared
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_pp[j][0] = r_g3_x[j][L_W-1:C] * r_g3_len2[L_W-1:C];
            n_pp[j][1] = r_g3_x[j][L_W-1:C] * r_g3_len2[C-1:0];
            n_pp[j][2] = r_g3_x[j][C-1:0]   * r_g3_len2[L_W-1:C];
            n_pp[j][3] = r_g3_x[j][C-1:0]   * r_g3_len2[C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g4_pp    <= n_pp;
        r_g4_flags <= r_g3_flags;
    end

    // stage 5: recombine partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_lim[j] = (S_W'(r_g4_pp[j][0]) << L_W) + (S_W'(r_g4_pp[j][1]) << C)
                     + (S_W'(r_g4_pp[j][2]) << C) + S_W'(r_g4_pp[j][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_g5_lim   <= n_lim;
        r_g5_flags <= r_g4_flags;
    end

    assign o_len2   = r_g3_len2;
    assign o_lim_in = r_g5_lim[0];
    assign o_lim_hi = r_g5_lim[1];
    assign o_lim_lo = r_g5_lim[2];
    assign o_flags  = r_g5_flags;

endmodule

### design/point_in_finite_cylinder_classifier.sv
// ----------------------------------------------------------------------------
// point_in_finite_cylinder_classifier
// Classifies signed fixed-point 3-D points against a configured finite
// cylinder. The block takes one point word per clock while o_stall is low
// and returns one word of three flags per point, in order, from the end of
// the eight-register pipeline, whose wide squares are built from half-width
// partial products over two stages. Each stage moves on its own when the
// next one is free, so a bubble is squeezed out and a point is still
// accepted while a finished result waits at the output, if a stage is free.
// The flags are found by exact comparison of squared distances scaled by
// the axis length squared, with no division or root. The user must write
// registers through the plain write port only while no point is in flight;
// the block does not enforce this. Derived terms are registered in pifc_geom.
// ----------------------------------------------------------------------------
module point_in_finite_cylinder_classifier #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pifc_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic signed [COORD_BITS-1:0]        i_point_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_within_slab,
    output logic                                o_inside_res,
    output logic                                o_near_surface
);
    import pifc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int RAD_W = COORD_BITS - 1;
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * COORD_BITS + 1;
    localparam int X_W   = 2 * COORD_BITS + 2;
    localparam int T_W   = 2 * COORD_BITS + 3;
    localparam int L_W   = 2 * COORD_BITS;
    localparam int M_W   = 2 * COORD_BITS;
    localparam int S_W   = 4 * COORD_BITS;
    localparam int Q_W   = 4 * COORD_BITS + 2;
    localparam int NS    = 8;

    // configuration registers
    logic signed [C-1:0]     r_base [3];
    logic signed [C-1:0]     r_axis [3];
    logic        [RAD_W-1:0] r_radius;
    logic        [RAD_W-1:0] r_band;

    logic        [L_W-1:0]   w_len2;
    logic        [S_W-1:0]   w_lim_in;
    logic        [S_W-1:0]   w_lim_hi;
    logic        [S_W-1:0]   w_lim_lo;
    t_geom_flags             w_flags;
    logic signed [T_W-1:0]   w_len2_s;

    logic        [NS-1:0]    r_vld;
    logic        [NS-1:0]    w_adv;

    logic signed [C-1:0]     w_pt [3];
    logic signed [D_W-1:0]   n_s1_d [3];
    logic signed [D_W-1:0]   r_s1_d [3];

    logic signed [P_W-1:0]   n_s2_dot [3];
    logic signed [P_W-1:0]   n_s2_xp [3];
    logic signed [P_W-1:0]   n_s2_xn [3];
    logic signed [P_W-1:0]   r_s2_dot [3];
    logic signed [P_W-1:0]   r_s2_xp [3];
    logic signed [P_W-1:0]   r_s2_xn [3];

    logic signed [T_W-1:0]   n_s3_t;
    logic signed [X_W-1:0]   n_s3_c [3];
    logic signed [T_W-1:0]   r_s3_t;
    logic signed [X_W-1:0]   r_s3_c [3];

    logic signed [X_W-1:0]   n_s4_neg [3];
    logic        [M_W-1:0]   n_s4_cabs [3];
    logic                    n_s4_slab;
    logic        [M_W-1:0]   r_s4_cabs [3];
    logic                    r_s4_slab;

    logic        [L_W-1:0]   n_s5_hh [3];
    logic        [L_W-1:0]   n_s5_hl [3];
    logic        [L_W-1:0]   n_s5_ll [3];
    logic        [L_W-1:0]   r_s5_hh [3];
    logic        [L_W-1:0]   r_s5_hl [3];
    logic        [L_W-1:0]   r_s5_ll [3];
    logic                    r_s5_slab;

    logic        [S_W-1:0]   n_s6_sq [3];
    logic        [S_W-1:0]   r_s6_sq [3];
    logic                    r_s6_slab;

    logic        [Q_W-1:0]   n_s7_q;
    logic        [Q_W-1:0]   r_s7_q;
    logic                    r_s7_slab;

    logic                    n_s8_slab;
    logic                    n_s8_inside;
    logic                    n_s8_near;
    logic                    r_s8_slab;
    logic                    r_s8_inside;
    logic                    r_s8_near;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_base[i] <= '0;
            end
            r_axis[0] <= '0;
            r_axis[1] <= '0;
            r_axis[2] <= C'(1) << FRAC_BITS;
            r_radius  <= RAD_W'(1) << FRAC_BITS;
            r_band    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BASE_X:         r_base[0] <= i_cfg_data;
                REG_BASE_Y:         r_base[1] <= i_cfg_data;
                REG_BASE_Z:         r_base[2] <= i_cfg_data;
                REG_AXIS_X:         r_axis[0] <= i_cfg_data;
                REG_AXIS_Y:         r_axis[1] <= i_cfg_data;
                REG_AXIS_Z:         r_axis[2] <= i_cfg_data;
                REG_RADIUS:         r_radius  <= i_cfg_data[RAD_W-1:0];
                REG_BAND_HALFWIDTH: r_band    <= i_cfg_data[RAD_W-1:0];
            endcase
        end
    end

    pifc_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk            (i_clk),
        .i_axis_x         (r_axis[0]),
        .i_axis_y         (r_axis[1]),
        .i_axis_z         (r_axis[2]),
        .i_radius         (r_radius),
        .i_band_halfwidth (r_band),
        .o_len2           (w_len2),
        .o_lim_in         (w_lim_in),
        .o_lim_hi         (w_lim_hi),
        .o_lim_lo         (w_lim_lo),
        .o_flags          (w_flags)
    );

    assign w_len2_s = $signed({{(T_W-L_W){1'b0}}, w_len2});

    // ------------------------------------------------------- flow control
    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[NS-1];

    // ------------------------------------------------------------ datapath
    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // stage 1: offset from base centre
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_d[i] = w_pt[i] - r_base[i];
        end
    end

    // stage 2: dot and cross products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s2_dot[i] = r_s1_d[i] * r_axis[i];
        end
        n_s2_xp[0] = r_s1_d[1] * r_axis[2];
        n_s2_xn[0] = r_s1_d[2] * r_axis[1];
        n_s2_xp[1] = r_s1_d[2] * r_axis[0];
        n_s2_xn[1] = r_s1_d[0] * r_axis[2];
        n_s2_xp[2] = r_s1_d[0] * r_axis[1];
        n_s2_xn[2] = r_s1_d[1] * r_axis[0];
    end

    // stage 3: projection and cross components
    always_comb begin
        n_s3_t = r_s2_dot[0] + r_s2_dot[1] + r_s2_dot[2];
        for (int i = 0; i < 3; i++) begin
            n_s3_c[i] = r_s2_xp[i] - r_s2_xn[i];
        end
    end

    // stage 4: slab test and magnitudes of the cross components
    always_comb begin
        n_s4_slab = !r_s3_t[T_W-1] && (r_s3_t <= w_len2_s);
        for (int i = 0; i < 3; i++) begin
            n_s4_neg[i]  = -r_s3_c[i];
            n_s4_cabs[i] = r_s3_c[i][X_W-1] ? n_s4_neg[i][M_W-1:0] : r_s3_c[i][M_W-1:0];
        end
    end

    // stage 5: half-width partial squares
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s5_hh[i] = r_s4_cabs[i][M_W-1:C] * r_s4_cabs[i][M_W-1:C];
            n_s5_hl[i] = r_s4_cabs[i][M_W-1:C] * r_s4_cabs[i][C-1:0];
            n_s5_ll[i] = r_s4_cabs[i][C-1:0]   * r_s4_cabs[i][C-1:0];
        end
    end

    // stage 6: recombine squares, cross term counted twice
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s6_sq[i] = (S_W'(r_s5_hh[i]) << L_W) + (S_W'(r_s5_hl[i]) << (C + 1))
                       + S_W'(r_s5_ll[i]);
        end
    end

    // stage 7: squared axis distance times length squared
    assign n_s7_q = Q_W'(r_s6_sq[0]) + Q_W'(r_s6_sq[1]) + Q_W'(r_s6_sq[2]);

    // stage 8: radius and band compares
    always_comb begin
        n_s8_slab   = r_s7_slab && !w_flags.axis_zero;
        n_s8_inside = n_s8_slab && (r_s7_q < Q_W'(w_lim_in));
        n_s8_near   = n_s8_slab && (r_s7_q <= Q_W'(w_lim_hi))
                   && (w_flags.lo_neg || (Q_W'(w_lim_lo) <= r_s7_q));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_d <= n_s1_d;
        end
        if (w_adv[1]) begin
            r_s2_dot <= n_s2_dot;
            r_s2_xp  <= n_s2_xp;
            r_s2_xn  <= n_s2_xn;
        end
        if (w_adv[2]) begin
            r_s3_t <= n_s3_t;
            r_s3_c <= n_s3_c;
        end
        if (w_adv[3]) begin
            r_s4_cabs <= n_s4_cabs;
            r_s4_slab <= n_s4_slab;
        end
        if (w_adv[4]) begin
            r_s5_hh   <= n_s5_hh;
            r_s5_hl   <= n_s5_hl;
            r_s5_ll   <= n_s5_ll;
            r_s5_slab <= r_s4_slab;
        end
        if (w_adv[5]) begin
            r_s6_sq   <= n_s6_sq;
            r_s6_slab <= r_s5_slab;
        end
        if (w_adv[6]) begin
            r_s7_q    <= n_s7_q;
            r_s7_slab <= r_s6_slab;
        end
        if (w_adv[7]) begin
            r_s8_slab   <= n_s8_slab;
            r_s8_inside <= n_s8_inside;
            r_s8_near   <= n_s8_near;
        end
    end

    assign o_within_slab  = r_s8_slab;
    assign o_inside_res   = r_s8_inside;
    assign o_near_surface = r_s8_near;

    // ---------------------------------------------------------- assertions
    a_inside_in_slab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_inside_res || o_within_slab))
        else $error("inside flag without slab flag");

    a_near_in_slab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_near_surface || o_within_slab))
        else $error("near-surface flag without slab flag");

    // input is held off only when every stage holds a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a free pipeline stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule
